/* design/obc_pkg.sv */
// package for the oriented box corner block: constants, types, cordic angle table
package obc_pkg;

  localparam int CordicStages = 16;
  localparam int AngW = 28;
  localparam int CW = 33;
  localparam logic signed [AngW-1:0] AngPi = 28'sd52707179;
  localparam logic signed [AngW-1:0] AngHalfPi = 28'sd26353589;
  localparam logic signed [CW-1:0] CordicX0 = 33'sd652032874;

  typedef struct packed {
    logic [15:0] id;
    logic [7:0] kind;
    logic signed [23:0] px;
    logic signed [23:0] py;
    logic [15:0] wd;
    logic [15:0] ln;
    logic signed [15:0] sp;
  } pass_t;

  function automatic logic signed [AngW-1:0] atan_q24(input logic [4:0] i);
    logic signed [AngW-1:0] r;
    case (i)
      5'd0: r = 28'sd13176795;
      5'd1: r = 28'sd7778716;
      5'd2: r = 28'sd4110060;
      5'd3: r = 28'sd2086331;
      5'd4: r = 28'sd1047214;
      5'd5: r = 28'sd524117;
      5'd6: r = 28'sd262123;
      5'd7: r = 28'sd131069;
      default: r = (i < 5'd24) ? AngW'(28'sd65536 >>> (i - 5'd8)) : '0;
    endcase
    return r;
  endfunction

endpackage

/* design/obc_cordic.sv */
// pipelined rotation-mode cordic giving rounded cos and sin in q.16
module obc_cordic (
  input  logic clk_i,
  input  logic en_i,
  input  logic signed [15:0] heading_i,
  output logic signed [17:0] cos_o,
  output logic signed [17:0] sin_o
);
  localparam int N = (obc_pkg::CordicStages > 24) ? 24 : obc_pkg::CordicStages;

  logic signed [obc_pkg::CW-1:0] x_q [N+1];
  logic signed [obc_pkg::CW-1:0] y_q [N+1];
  logic signed [obc_pkg::AngW-1:0] z_q [N+1];
  logic neg_q [N+1];
  logic signed [obc_pkg::AngW-1:0] z0;
  logic signed [obc_pkg::CW-1:0] xf, yf;

  assign z0 = obc_pkg::AngW'(heading_i) <<< 11;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0] <= obc_pkg::CordicX0;
      y_q[0] <= '0;
      neg_q[0] <= (z0 > obc_pkg::AngHalfPi) || (z0 < -obc_pkg::AngHalfPi);
      if (z0 > obc_pkg::AngHalfPi) z_q[0] <= z0 - obc_pkg::AngPi;
      else if (z0 < -obc_pkg::AngHalfPi) z_q[0] <= z0 + obc_pkg::AngPi;
      else z_q[0] <= z0;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_stage
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        neg_q[i+1] <= neg_q[i];
        if (z_q[i] >= 0) begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] - obc_pkg::atan_q24(5'(i));
        end else begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] + obc_pkg::atan_q24(5'(i));
        end
      end
    end
  end

  assign xf = neg_q[N] ? -x_q[N] : x_q[N];
  assign yf = neg_q[N] ? -y_q[N] : y_q[N];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cos_o <= 18'((xf + 33'sd8192) >>> 14);
      sin_o <= 18'((yf + 33'sd8192) >>> 14);
    end
  end
endmodule

/* design/oriented_box_to_corners.sv */
// oriented box corners: top level with cordic, products and corner sums
// throughput: one beat per cycle while the output is taken, set by the fully pipelined cordic and multipliers
// a full output beat that is not taken freezes the whole pipeline and the input
// reset: asynchronous active low, clears the valid bits only
module oriented_box_to_corners (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // id[15:0] type[23:16] pos_x[47:24] pos_y[71:48] box_width[87:72]
  // box_length[103:88] heading[119:104] speed[135:120]
  input  logic [135:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // id_out[15:0] type_out[23:16] rear_right_x/y[71:24] front_right_x/y[119:72]
  // rear_left_x/y[167:120] front_left_x/y[215:168] vel_x[231:216] vel_y[247:232]
  output logic [247:0] m_axis_tdata
);
  localparam int N = (obc_pkg::CordicStages > 24) ? 24 : obc_pkg::CordicStages;
  localparam int L = N + 2; // cordic output register stage index
  localparam int D = L + 3;

  logic en;
  logic [D-1:0] v_q;
  obc_pkg::pass_t p_q [L];
  obc_pkg::pass_t pin;
  logic signed [17:0] c, s;

  assign pin = '{id: s_axis_tdata[15:0], kind: s_axis_tdata[23:16],
                 px: s_axis_tdata[47:24], py: s_axis_tdata[71:48],
                 wd: s_axis_tdata[87:72], ln: s_axis_tdata[103:88],
                 sp: s_axis_tdata[135:120]};

  // pipeline advances unless the last stage is full and blocked
  assign en = !(v_q[D-1] && !m_axis_tready);
  assign s_axis_tready = en;
  assign m_axis_tvalid = v_q[D-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[D-2:0], s_axis_tvalid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_q[0] <= pin;
      for (int k = 1; k < L; k++) p_q[k] <= p_q[k-1];
    end
  end

  obc_cordic u_cordic (
    .clk_i, .en_i(en),
    .heading_i(s_axis_tdata[119:104]),
    .cos_o(c), .sin_o(s)
  );

  // products stage
  logic signed [34:0] lc_q, ls_q, wc_q, ws_q;
  logic signed [34:0] vx_q, vy_q;
  obc_pkg::pass_t pm_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      pm_q <= p_q[L-1];
      lc_q <= $signed({1'b0, p_q[L-1].ln}) * c;
      ls_q <= $signed({1'b0, p_q[L-1].ln}) * s;
      wc_q <= $signed({1'b0, p_q[L-1].wd}) * c;
      ws_q <= $signed({1'b0, p_q[L-1].wd}) * s;
      vx_q <= p_q[L-1].sp * c;
      vy_q <= p_q[L-1].sp * s;
    end
  end

  // partial sums stage
  logic signed [42:0] bx_q, by_q;
  logic signed [35:0] al_q, as_q, bl_q, bs_q;
  logic [15:0] id_q, id2_q;
  logic [7:0] ty_q, ty2_q;
  logic signed [15:0] vxr_q, vyr_q, vxr2_q, vyr2_q;

  function automatic logic signed [15:0] rnd16(input logic signed [34:0] v);
    logic signed [35:0] t;
    t = (36'(v) + 36'sd32768) >>> 16;
    if (t > 36'sd32767) return 16'sh7fff;
    if (t < -36'sd32768) return 16'sh8000;
    return t[15:0];
  endfunction

  function automatic logic signed [23:0] corner(input logic signed [42:0] base,
      input logic signed [35:0] a, input logic signed [35:0] b);
    logic signed [43:0] t;
    t = (44'(base) + 44'(a) + 44'(b) + 44'sd65536) >>> 17;
    if (t > 44'sd8388607) return 24'h7fffff;
    if (t < -44'sd8388608) return 24'h800000;
    return t[23:0];
  endfunction

  always_ff @(posedge clk_i) begin
    if (en) begin
      bx_q <= 43'(pm_q.px) <<< 17;
      by_q <= 43'(pm_q.py) <<< 17;
      al_q <= 36'(lc_q); as_q <= 36'(ws_q);
      bl_q <= 36'(ls_q); bs_q <= 36'(wc_q);
      id_q <= pm_q.id; ty_q <= pm_q.kind;
      vxr_q <= rnd16(vx_q); vyr_q <= rnd16(vy_q);
    end
  end

  logic [191:0] cor_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      id2_q <= id_q; ty2_q <= ty_q; vxr2_q <= vxr_q; vyr2_q <= vyr_q;
      cor_q[23:0]    <= corner(bx_q, -al_q,  as_q);
      cor_q[47:24]   <= corner(by_q, -bl_q, -bs_q);
      cor_q[71:48]   <= corner(bx_q,  al_q,  as_q);
      cor_q[95:72]   <= corner(by_q,  bl_q, -bs_q);
      cor_q[119:96]  <= corner(bx_q, -al_q, -as_q);
      cor_q[143:120] <= corner(by_q, -bl_q,  bs_q);
      cor_q[167:144] <= corner(bx_q,  al_q, -as_q);
      cor_q[191:168] <= corner(by_q,  bl_q,  bs_q);
    end
  end

  assign m_axis_tdata = {vyr2_q, vxr2_q, cor_q, ty2_q, id2_q};

`ifndef SYNTH
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output changed under stall");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input blocked while output empty");
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |=> $countones(v_q) <= D)
    else $error("valid count out of range");
`endif
endmodule

/* sim/tb_top.sv */
// testbench for oriented_box_to_corners: stream driver, monitor and corner predictor
`timescale 1ns / 100ps

module tb_top;

  localparam int NumRandom = 750;
  localparam int Latency = obc_pkg::CordicStages + 5;

  typedef struct packed {
    logic [15:0] vel_y;
    logic [15:0] vel_x;
    logic signed [23:0] fl_y, fl_x, rl_y, rl_x, fr_y, fr_x, rr_y, rr_x;
    logic [7:0] kind;
    logic [15:0] id;
  } corners_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [135:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [247:0] m_axis_tdata;

  logic [135:0] pending_objs[$];
  corners_t expected_corners[$];
  int mismatches = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  bit hold_go = 1'b0;
  bit holding = 1'b0;
  bit s_fire = 1'b0;

  always #2 clk_i = ~clk_i;

  oriented_box_to_corners uut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint clamp(longint v, int w);
    longint hi, lo;
    hi = (64'sd1 <<< (w - 1)) - 1;
    lo = -(64'sd1 <<< (w - 1));
    return (v > hi) ? hi : (v < lo) ? lo : v;
  endfunction

  function automatic logic [23:0] corner_coord(longint ctr, longint a, longint b);
    return 24'(clamp(floor_shift(ctr * 131072 + a + b + 65536, 17), 24));
  endfunction

  function automatic corners_t predict_corners(logic [135:0] d);
    corners_t r;
    longint px, py, wd, ln, hd, sp, z, x, y, nx, ny, c, s, lc, ls, wc, ws, ang;
    int n;
    bit flip;
    px = longint'($signed(d[47:24]));
    py = longint'($signed(d[71:48]));
    wd = longint'(d[87:72]);
    ln = longint'(d[103:88]);
    hd = longint'($signed(d[119:104]));
    sp = longint'($signed(d[135:120]));
    z = hd * 2048;
    flip = 1'b0;
    if (z > 26353589) begin
      z -= 52707179;
      flip = 1'b1;
    end else if (z < -26353589) begin
      z += 52707179;
      flip = 1'b1;
    end
    x = 652032874;
    y = 0;
    n = (obc_pkg::CordicStages > 24) ? 24 : obc_pkg::CordicStages;
    for (int i = 0; i < n; i++) begin
      case (i)
        0: ang = 13176795;
        1: ang = 7778716;
        2: ang = 4110060;
        3: ang = 2086331;
        4: ang = 1047214;
        5: ang = 524117;
        6: ang = 262123;
        7: ang = 131069;
        default: ang = 65536 >>> (i - 8);
      endcase
      if (z >= 0) begin
        nx = x - floor_shift(y, i);
        ny = y + floor_shift(x, i);
        z -= ang;
      end else begin
        nx = x + floor_shift(y, i);
        ny = y - floor_shift(x, i);
        z += ang;
      end
      x = nx;
      y = ny;
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    c = floor_shift(x + 8192, 14);
    s = floor_shift(y + 8192, 14);
    lc = ln * c;
    ls = ln * s;
    wc = wd * c;
    ws = wd * s;
    r.id = d[15:0];
    r.kind = d[23:16];
    r.rr_x = corner_coord(px, -lc, ws);
    r.rr_y = corner_coord(py, -ls, -wc);
    r.fr_x = corner_coord(px, lc, ws);
    r.fr_y = corner_coord(py, ls, -wc);
    r.rl_x = corner_coord(px, -lc, -ws);
    r.rl_y = corner_coord(py, -ls, wc);
    r.fl_x = corner_coord(px, lc, -ws);
    r.fl_y = corner_coord(py, ls, wc);
    r.vel_x = 16'(clamp(floor_shift(sp * c + 32768, 16), 16));
    r.vel_y = 16'(clamp(floor_shift(sp * s + 32768, 16), 16));
    return r;
  endfunction

  function automatic logic [135:0] pack_obj(logic [15:0] id, logic [7:0] kind,
      logic [23:0] px, logic [23:0] py, logic [15:0] wd, logic [15:0] ln,
      logic [15:0] hd, logic [15:0] sp);
    return {sp, hd, ln, wd, py, px, kind, id};
  endfunction

  function automatic logic [135:0] random_obj();
    logic [23:0] px, py;
    logic [15:0] wd, ln, hd;
    px = 24'($urandom);
    py = 24'($urandom);
    wd = 16'($urandom);
    ln = 16'($urandom);
    hd = 16'($urandom);
    // mostly realistic objects, the rest full range
    if ($urandom_range(0, 3) != 0) begin
      px = 24'($signed($urandom_range(0, 200000)) - 100000);
      py = 24'($signed($urandom_range(0, 200000)) - 100000);
      wd = 16'($urandom_range(0, 2000));
      ln = 16'($urandom_range(0, 5000));
      hd = 16'($signed($urandom_range(0, 51472)) - 25736);
    end
    return pack_obj(16'($urandom), 8'($urandom), px, py, wd, ln, hd, 16'($urandom));
  endfunction

  function automatic void add_obj(logic [135:0] d);
    pending_objs.insert(pending_objs.size(), d);
  endfunction

  // input beat taken at the last rising edge
  always @(posedge clk_i) begin
    s_fire <= s_axis_tvalid && s_axis_tready;
  end

  // driver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid || s_fire) begin
        if (pending_objs.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= pending_objs.pop_front();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      m_axis_tready <= !holding && ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // back-pressure stretch, counted in cycles
  initial begin
    wait (hold_go);
    holding = 1'b1;
    repeat (200) @(posedge clk_i);
    holding = 1'b0;
  end

  // monitor
  always @(posedge clk_i) begin
    corners_t got, want;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_corners.insert(expected_corners.size(), predict_corners(s_axis_tdata));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = corners_t'(m_axis_tdata);
        if (expected_corners.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected beat %h", m_axis_tdata);
        end else begin
          want = expected_corners.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch id %h: expected %h", want.id, want);
              $display("                actual   %h", got);
            end
          end
        end
      end
    end
  end

  task automatic run_phase(int n, int idle, int stall);
    idle_pct = idle;
    stall_pct = stall;
    for (int i = 0; i < n; i++) add_obj(random_obj());
    wait (pending_objs.size() == 0);
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    // directed: extremes, quadrant edges, saturation, zero sizes
    add_obj(pack_obj(16'h0000, 8'h00, 24'h000000, 24'h000000, 16'h0000,
                     16'h0000, 16'h0000, 16'h0000));
    add_obj(pack_obj(16'hffff, 8'hff, 24'h7fffff, 24'h7fffff, 16'hffff,
                     16'hffff, 16'h7fff, 16'h7fff));
    add_obj(pack_obj(16'h1234, 8'h5a, 24'h800000, 24'h800000, 16'hffff,
                     16'hffff, 16'h8000, 16'h8000));
    add_obj(pack_obj(16'h0001, 8'h01, 24'h7fff00, 24'h800100, 16'h0400,
                     16'h0800, 16'h3244, 16'h0100));
    add_obj(pack_obj(16'h0002, 8'h02, 24'h001000, 24'hfff000, 16'h0400,
                     16'h0800, 16'h3243, 16'hff00));
    add_obj(pack_obj(16'h0003, 8'h03, 24'h000000, 24'h000000, 16'h0200,
                     16'h0300, 16'hcdbc, 16'h0100));
    add_obj(pack_obj(16'h0004, 8'h04, 24'h000000, 24'h000000, 16'h0200,
                     16'h0300, 16'hcdbd, 16'h0100));
    add_obj(pack_obj(16'h0005, 8'h05, 24'h000100, 24'h000100, 16'h0100,
                     16'h0100, 16'h6488, 16'h0100));
    add_obj(pack_obj(16'h0006, 8'h06, 24'h000100, 24'h000100, 16'h0100,
                     16'h0100, 16'h9b78, 16'h7fff));
    add_obj(pack_obj(16'h0007, 8'h07, 24'h7ffff0, 24'h80000f, 16'hffff,
                     16'hffff, 16'h1922, 16'h8000));
    add_obj(pack_obj(16'h0008, 8'h08, 24'h7ffff0, 24'h80000f, 16'h0000,
                     16'hffff, 16'he6de, 16'h7fff));
    wait (pending_objs.size() == 0);
    run_phase(150, 0, 0);
    // long back-pressure while the sender keeps offering
    idle_pct = 0;
    stall_pct = 0;
    hold_go = 1'b1;
    for (int i = 0; i < 100; i++) add_obj(random_obj());
    wait (pending_objs.size() == 0);
    run_phase(150, 87, 0);
    run_phase(150, 0, 87);
    run_phase(150, 28, 28);
    run_phase(50, 0, 0);
    wait (!s_axis_tvalid || s_axis_tready);
    @(posedge clk_i);
    wait (expected_corners.size() == 0);
    repeat (Latency + 10) @(posedge clk_i);
    if (mismatches == 0 && expected_corners.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
